@@ rtl/core/pidc_pkg.sv @@
// Shared types, widths and register codes for the PID step controller.
// No dependencies; every other file in rtl/core imports this package.
package pidc_pkg;

    localparam int GAIN_W                 = 16;
    localparam int GAIN_FRAC              = 12;
    localparam int DRIVE_W                = 24;
    localparam int CFG_INDEX_W            = 2;
    localparam int ERROR_WIDTH_DEFAULT    = 16;
    localparam int INTEGRAL_WIDTH_DEFAULT = 24;
    localparam int QUEUE_DEPTH            = 4;
    localparam int PIPE_STAGES            = 3;

    typedef logic [GAIN_W-1:0]         gain_t;
    typedef logic signed [DRIVE_W-1:0] drive_t;
    typedef logic [CFG_INDEX_W-1:0]    cfg_index_t;

    localparam cfg_index_t REG_GAIN_P = 2'd0;
    localparam cfg_index_t REG_GAIN_I = 2'd1;
    localparam cfg_index_t REG_GAIN_D = 2'd2;

    localparam drive_t DRIVE_MAX = 24'sh7FFFFF;
    localparam drive_t DRIVE_MIN = 24'sh800000;

    typedef struct packed {
        gain_t p;
        gain_t i;
        gain_t d;
    } gains_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

@@ rtl/core/pid_controller_step.sv @@
// Top level of the discrete PID step controller: gain registers, front, queue, back.
// Depends on pidc_pkg, pidc_front, pidc_queue and pidc_back.
//
//   channel   direction  handshake            payload
//   -------   ---------  ---------            -------
//   in        request    in_valid / in_stall  error_sample, restart
//   out       result     out_valid/out_stall  drive_value, saturated
//   cfg       write      cfg_write            cfg_index, cfg_data
//
// One request per cycle while the queue has room; a result is registered in turn by the front
// update and queue write, the multiply stage, the sum stage and the output register.
// The front end registers the integral/previous-sample update on each accepted request.
// Reset clears gains, integral, previous sample, queue and all valid bits.
// An output stall while a result is valid holds the three back stages; the four-entry queue keeps
// taking requests until it fills, then in_stall rises.
module pid_controller_step #(
    parameter int ERROR_WIDTH    = pidc_pkg::ERROR_WIDTH_DEFAULT,
    parameter int INTEGRAL_WIDTH = pidc_pkg::INTEGRAL_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [ERROR_WIDTH-1:0] error_sample,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_stall,
    output pidc_pkg::drive_t              drive_value,
    output logic                          saturated,
    input  logic                          cfg_write,
    input  pidc_pkg::cfg_index_t          cfg_index,
    input  pidc_pkg::gain_t               cfg_data
);
    import pidc_pkg::*;

    localparam int ENTRY_W = 2 * ERROR_WIDTH + INTEGRAL_WIDTH + 2;

    gains_t                           gains_reg, gains_next;
    queue_status_t                    q_status;
    logic                             push, pop;
    logic [ENTRY_W-1:0]               push_data, pop_data;
    logic signed [ERROR_WIDTH-1:0]    push_error, pop_error;
    logic signed [INTEGRAL_WIDTH-1:0] push_integral, pop_integral;
    logic signed [ERROR_WIDTH:0]      push_delta, pop_delta;
    logic                             push_sat, pop_sat;

    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GAIN_P: gains_next.p = cfg_data;
                REG_GAIN_I: gains_next.i = cfg_data;
                REG_GAIN_D: gains_next.d = cfg_data;
                default:    gains_next = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg <= '0;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

    pidc_front #(
        .ERROR_WIDTH    (ERROR_WIDTH),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .error_sample  (error_sample),
        .restart       (restart),
        .q_status      (q_status),
        .push          (push),
        .push_error    (push_error),
        .push_integral (push_integral),
        .push_delta    (push_delta),
        .push_sat      (push_sat)
    );

    assign push_data = {push_sat, push_delta, push_integral, push_error};

    pidc_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    assign pop_error    = $signed(pop_data[ERROR_WIDTH-1:0]);
    assign pop_integral = $signed(pop_data[ERROR_WIDTH +: INTEGRAL_WIDTH]);
    assign pop_delta    = $signed(pop_data[ERROR_WIDTH + INTEGRAL_WIDTH +: ERROR_WIDTH + 1]);
    assign pop_sat      = pop_data[ENTRY_W-1];

    pidc_back #(
        .ERROR_WIDTH    (ERROR_WIDTH),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .gains        (gains_reg),
        .q_status     (q_status),
        .pop          (pop),
        .pop_error    (pop_error),
        .pop_integral (pop_integral),
        .pop_delta    (pop_delta),
        .pop_sat      (pop_sat),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive_value  (drive_value),
        .saturated    (saturated)
    );

endmodule

@@ rtl/core/pidc_front.sv @@
// Front end: takes error requests, updates integral and previous sample.
// Depends on pidc_pkg; pushes one classified entry per request into the queue.
module pidc_front #(
    parameter int ERROR_WIDTH    = pidc_pkg::ERROR_WIDTH_DEFAULT,
    parameter int INTEGRAL_WIDTH = pidc_pkg::INTEGRAL_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [ERROR_WIDTH-1:0]    error_sample,
    input  logic                             restart,
    input  pidc_pkg::queue_status_t          q_status,
    output logic                             push,
    output logic signed [ERROR_WIDTH-1:0]    push_error,
    output logic signed [INTEGRAL_WIDTH-1:0] push_integral,
    output logic signed [ERROR_WIDTH:0]      push_delta,
    output logic                             push_sat
);
    import pidc_pkg::*;

    localparam int ACC_W = ((INTEGRAL_WIDTH > ERROR_WIDTH) ? INTEGRAL_WIDTH : ERROR_WIDTH) + 1;
    localparam longint IMAX_L = (longint'(1) << (INTEGRAL_WIDTH - 1)) - 1;
    localparam logic signed [ACC_W-1:0] IMAX = ACC_W'(IMAX_L);
    localparam logic signed [ACC_W-1:0] IMIN = ACC_W'(-IMAX_L - 1);

    logic signed [INTEGRAL_WIDTH-1:0] integral_reg, integral_next;
    logic signed [ERROR_WIDTH-1:0]    previous_reg, previous_next;
    logic signed [INTEGRAL_WIDTH-1:0] base_integral;
    logic signed [ERROR_WIDTH-1:0]    base_previous;
    logic signed [ACC_W-1:0]          acc_sum;
    logic signed [INTEGRAL_WIDTH-1:0] acc_clamped;
    logic                             acc_sat;

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    always_comb
    begin
        base_integral = restart ? '0 : integral_reg;
        base_previous = restart ? '0 : previous_reg;
        acc_sum = ACC_W'(base_integral) + ACC_W'(error_sample);
        acc_sat = 1'b0;
        if (acc_sum > IMAX)
        begin
            acc_clamped = IMAX[INTEGRAL_WIDTH-1:0];
            acc_sat     = 1'b1;
        end
        else if (acc_sum < IMIN)
        begin
            acc_clamped = IMIN[INTEGRAL_WIDTH-1:0];
            acc_sat     = 1'b1;
        end
        else
        begin
            acc_clamped = acc_sum[INTEGRAL_WIDTH-1:0];
        end
        integral_next = push ? acc_clamped : integral_reg;
        previous_next = push ? error_sample : previous_reg;
    end

    assign push_error    = error_sample;
    assign push_integral = acc_clamped;
    assign push_delta    = (ERROR_WIDTH + 1)'(error_sample) - (ERROR_WIDTH + 1)'(base_previous);
    assign push_sat      = acc_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            previous_reg <= '0;
        end
        else
        begin
            integral_reg <= integral_next;
            previous_reg <= previous_next;
        end
    end

endmodule

@@ rtl/core/pidc_queue.sv @@
// Short FIFO between front and back ends of the PID step controller.
// Depends on pidc_pkg for the status struct; entry width is a parameter.
module pidc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pidc_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [WIDTH-1:0]        push_data,
    input  logic                    pop,
    output logic [WIDTH-1:0]        pop_data,
    output pidc_pkg::queue_status_t status
);
    import pidc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/pidc_back.sv @@
// Back end: gain multiply, weighted sum with rounding, negate and saturate.
// Depends on pidc_pkg; three stages that advance together under output stall.
module pidc_back #(
    parameter int ERROR_WIDTH    = pidc_pkg::ERROR_WIDTH_DEFAULT,
    parameter int INTEGRAL_WIDTH = pidc_pkg::INTEGRAL_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pidc_pkg::gains_t                 gains,
    input  pidc_pkg::queue_status_t          q_status,
    output logic                             pop,
    input  logic signed [ERROR_WIDTH-1:0]    pop_error,
    input  logic signed [INTEGRAL_WIDTH-1:0] pop_integral,
    input  logic signed [ERROR_WIDTH:0]      pop_delta,
    input  logic                             pop_sat,
    output logic                             out_valid,
    input  logic                             out_stall,
    output pidc_pkg::drive_t                 drive_value,
    output logic                             saturated
);
    import pidc_pkg::*;

    localparam int PP_W = ERROR_WIDTH + GAIN_W + 1;
    localparam int PI_W = INTEGRAL_WIDTH + GAIN_W + 1;
    localparam int PD_W = ERROR_WIDTH + GAIN_W + 2;
    localparam int SW_A = INTEGRAL_WIDTH + GAIN_W + 3;
    localparam int SW_B = ERROR_WIDTH + GAIN_W + 4;
    localparam int SW_AB = (SW_A > SW_B) ? SW_A : SW_B;
    localparam int SUM_W = (SW_AB > 40) ? SW_AB : 40;
    localparam int Q_W = SUM_W - GAIN_FRAC;
    localparam longint Q_HIGH_L = longint'(1) << (DRIVE_W - 1);
    localparam logic signed [Q_W-1:0]   Q_HIGH = Q_W'(Q_HIGH_L);
    localparam logic signed [Q_W-1:0]   Q_LOW  = Q_W'(1 - Q_HIGH_L);
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (GAIN_FRAC - 1);

    logic                    advance;
    logic                    p_valid_reg, s_valid_reg, out_valid_reg;
    logic signed [PP_W-1:0]  prod_p_reg, prod_p_next;
    logic signed [PI_W-1:0]  prod_i_reg, prod_i_next;
    logic signed [PD_W-1:0]  prod_d_reg, prod_d_next;
    logic                    p_sat_reg;
    logic signed [SUM_W-1:0] sum_full;
    logic signed [Q_W-1:0]   q_reg, q_next;
    logic                    s_sat_reg;
    logic signed [Q_W-1:0]   q_neg;
    drive_t                  drive_reg, drive_next;
    logic                    sat_reg, sat_next;

    // hold every stage while a finished result waits
    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && !q_status.empty;

    always_comb
    begin
        prod_p_next = $signed({{ERROR_WIDTH{1'b0}}, 1'b0, gains.p})
                    * $signed({{(GAIN_W + 1){pop_error[ERROR_WIDTH-1]}}, pop_error});
        prod_i_next = $signed({{INTEGRAL_WIDTH{1'b0}}, 1'b0, gains.i})
                    * $signed({{(GAIN_W + 1){pop_integral[INTEGRAL_WIDTH-1]}}, pop_integral});
        prod_d_next = $signed({{(ERROR_WIDTH + 1){1'b0}}, 1'b0, gains.d})
                    * $signed({{(GAIN_W + 1){pop_delta[ERROR_WIDTH]}}, pop_delta});
    end

    // round half up, then floor by the gain scale
    always_comb
    begin
        sum_full = SUM_W'(prod_p_reg) + SUM_W'(prod_i_reg) + SUM_W'(prod_d_reg) + ROUND_BIAS;
        q_next   = $signed(sum_full[SUM_W-1:GAIN_FRAC]);
    end

    always_comb
    begin
        q_neg    = -q_reg;
        sat_next = s_sat_reg;
        if (q_reg > Q_HIGH)
        begin
            drive_next = DRIVE_MIN;
            sat_next   = 1'b1;
        end
        else if (q_reg < Q_LOW)
        begin
            drive_next = DRIVE_MAX;
            sat_next   = 1'b1;
        end
        else
        begin
            drive_next = q_neg[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
            p_sat_reg  <= pop_sat;
            q_reg      <= q_next;
            s_sat_reg  <= p_sat_reg;
            drive_reg  <= drive_next;
            sat_reg    <= sat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p_valid_reg   <= pop;
            s_valid_reg   <= p_valid_reg;
            out_valid_reg <= s_valid_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive_value = drive_reg;
    assign saturated   = sat_reg;

endmodule

@@ rtl/core/pidc_checker.sv @@
// Port-level checks for pid_controller_step, bound to the top level.
// Depends on pidc_pkg for queue depth, stage count and drive type.
module pidc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input pidc_pkg::drive_t drive_value,
    input logic             saturated
);
    import pidc_pkg::*;

    localparam int CAPACITY = QUEUE_DEPTH + PIPE_STAGES;
    localparam int CNT_W    = $clog2(CAPACITY + 2);

    logic             in_acc, out_acc;
    logic [CNT_W-1:0] pending_reg, pending_next;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    // count requests taken but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pending_reg != '0)
        else $error("result delivered with no request outstanding");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CNT_W'(CAPACITY))
        else $error("more requests in flight than queue and stages hold");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> pending_reg >= CNT_W'(QUEUE_DEPTH))
        else $error("input stalled while queue has room");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive_value) && $stable(saturated))
        else $error("stalled result changed or dropped");

endmodule

bind pid_controller_step pidc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive_value (drive_value),
    .saturated   (saturated)
);

@@ tb/testbench.sv @@
// Self-checking bench for pid_controller_step: directed table, then windup and noise phases.
// Depends on pidc_pkg and the pid_controller_step RTL; predicts each drive value in-bench.
module testbench;
    import pidc_pkg::*;

    localparam int ERROR_W       = ERROR_WIDTH_DEFAULT;
    localparam int INTEG_W       = INTEGRAL_WIDTH_DEFAULT;
    localparam int ITEMS_TOTAL   = 900;
    localparam int QUIET_TAIL    = 100;
    localparam int WINDUP_LEN    = 290;
    localparam int SETTLE_CYCLES = PIPE_STAGES + 2;
    localparam int QUIET_LIMIT   = 1000;
    localparam longint ROUND_HALF  = longint'(1) << (GAIN_FRAC - 1);
    localparam longint INTEG_MAX   = (longint'(1) << (INTEG_W - 1)) - 1;
    localparam longint INTEG_MIN   = -(longint'(1) << (INTEG_W - 1));
    localparam cfg_index_t REG_UNUSED = 2'd3;

    typedef enum logic {ROW_GAINS, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        gain_t                      p;
        gain_t                      i;
        gain_t                      d;
        logic signed [ERROR_W-1:0]  err;
        logic                       restart;
        logic                       typed;
        drive_t                     drive;
        logic                       sat;
    } stim_row_t;

    typedef struct packed {
        drive_t drive;
        logic   sat;
    } drive_result_t;

    localparam int DIRECTED_ROWS = 26;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // gains still at reset: no drive at all
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, 16'sd0, 1'b0, 1'b1, 24'sd0, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, 16'sd32767, 1'b0, 1'b1, 24'sd0, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, -16'sd32768, 1'b1, 1'b1, 24'sd0, 1'b0},
        // unity proportional gain: drive is the negated sample
        '{ROW_GAINS, 16'd4096, 16'd0, 16'd0, 16'sd0, 1'b0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, 16'sd32767, 1'b1, 1'b1, -24'sd32767, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, -16'sd32768, 1'b0, 1'b1, 24'sd32768, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, 16'sd1, 1'b0, 1'b1, -24'sd1, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, 16'sd0, 1'b0, 1'b1, 24'sd0, 1'b0},
        // smallest gain: round half up around +/-2048
        '{ROW_GAINS, 16'd1, 16'd0, 16'd0, 16'sd0, 1'b0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, 16'sd2047, 1'b1, 1'b1, 24'sd0, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, 16'sd2048, 1'b0, 1'b1, -24'sd1, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, -16'sd2048, 1'b0, 1'b1, 24'sd0, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, -16'sd2049, 1'b0, 1'b1, 24'sd1, 1'b0},
        // derivative only
        '{ROW_GAINS, 16'd0, 16'd0, 16'd4096, 16'sd0, 1'b0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, 16'sd100, 1'b1, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, -16'sd32768, 1'b0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, 16'sd32767, 1'b0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, 16'sd5, 1'b1, 1'b0, 24'sd0, 1'b0},
        // integral only
        '{ROW_GAINS, 16'd0, 16'd4096, 16'd0, 16'sd0, 1'b0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, 16'sd32767, 1'b1, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, 16'sd32767, 1'b0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, -16'sd32768, 1'b0, 1'b0, 24'sd0, 1'b0},
        // all gains at maximum
        '{ROW_GAINS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sd0, 1'b0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, 16'sd32767, 1'b1, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, -16'sd32768, 1'b0, 1'b0, 24'sd0, 1'b0},
        '{ROW_SAMPLE, 16'd0, 16'd0, 16'd0, 16'sd32767, 1'b0, 1'b0, 24'sd0, 1'b0}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [ERROR_W-1:0] error_sample;
    logic                      restart;
    logic                      out_valid;
    logic                      out_stall;
    drive_t                    drive_value;
    logic                      saturated;
    logic                      cfg_write;
    cfg_index_t                cfg_index;
    gain_t                     cfg_data;

    // predictor state
    gain_t                     gain_p;
    gain_t                     gain_i;
    gain_t                     gain_d;
    logic signed [INTEG_W-1:0] integral_state;
    logic signed [ERROR_W-1:0] prev_error_state;

    drive_result_t expected_drive_q[$];
    int            mismatch_count;
    int            items_sent;
    int            quiet_cycles;
    logic          idle_enabled;

    pid_controller_step dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .error_sample (error_sample),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive_value  (drive_value),
        .saturated    (saturated),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void store_register(input cfg_index_t idx, input gain_t value);
        case (idx)
            REG_GAIN_P: gain_p = value;
            REG_GAIN_I: gain_i = value;
            REG_GAIN_D: gain_d = value;
            default: ;
        endcase
    endfunction

    // Advance integral and previous sample, then return the expected drive.
    function automatic drive_result_t advance_controller(
        input logic signed [ERROR_W-1:0] err,
        input logic                      clear
    );
        longint        sample;
        longint        acc;
        longint        delta;
        longint        sum;
        longint        drive;
        drive_result_t res;
        sample = err;
        res.sat = 1'b0;
        if (clear)
        begin
            integral_state   = '0;
            prev_error_state = '0;
        end
        acc = longint'(integral_state) + sample;
        if (acc > INTEG_MAX)
        begin
            acc = INTEG_MAX;
            res.sat = 1'b1;
        end
        if (acc < INTEG_MIN)
        begin
            acc = INTEG_MIN;
            res.sat = 1'b1;
        end
        integral_state = acc[INTEG_W-1:0];
        delta = sample - longint'(prev_error_state);
        prev_error_state = err;
        sum = longint'(gain_p) * sample + longint'(gain_d) * delta
            + longint'(gain_i) * acc + ROUND_HALF;
        drive = -(sum >>> GAIN_FRAC);
        if (drive > longint'(DRIVE_MAX))
        begin
            drive = longint'(DRIVE_MAX);
            res.sat = 1'b1;
        end
        if (drive < longint'(DRIVE_MIN))
        begin
            drive = longint'(DRIVE_MIN);
            res.sat = 1'b1;
        end
        res.drive = drive[DRIVE_W-1:0];
        return res;
    endfunction

    function automatic gain_t pick_gain();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 16'hFFFF;
            2: return 16'd4096;
            3: return gain_t'($urandom_range(0, 255));
            default: return gain_t'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic signed [ERROR_W-1:0] random_error();
        case ($urandom_range(0, 7))
            0: return 16'sd32767;
            1: return -16'sd32768;
            2: return 16'($urandom_range(0, 32)) - 16'sd16;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Present one request, hold it until accepted, then queue its expected result.
    task automatic send_request(
        input logic signed [ERROR_W-1:0] err,
        input logic                      clear,
        input logic                      typed,
        input drive_result_t             typed_result
    );
        drive_result_t predicted;
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        error_sample <= err;
        restart      <= clear;
        do @(posedge clk); while (in_stall);
        predicted = advance_controller(err, clear);
        expected_drive_q.push_back(typed ? typed_result : predicted);
        items_sent++;
        if (items_sent >= ITEMS_TOTAL - QUIET_TAIL)
            idle_enabled = 1'b0;
    endtask

    // Drop valid and wait until every queued result is back and the pipe is empty.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_drive_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_gains(input gain_t p, input gain_t i, input gain_t d);
        gain_t junk;
        junk = gain_t'($urandom_range(0, 65535));
        cfg_write <= 1'b1;
        cfg_index <= REG_GAIN_P;
        cfg_data  <= p;
        @(posedge clk);
        store_register(REG_GAIN_P, p);
        cfg_index <= REG_GAIN_I;
        cfg_data  <= i;
        @(posedge clk);
        store_register(REG_GAIN_I, i);
        cfg_index <= REG_GAIN_D;
        cfg_data  <= d;
        @(posedge clk);
        store_register(REG_GAIN_D, d);
        // out-of-range index must be ignored
        cfg_index <= REG_UNUSED;
        cfg_data  <= junk;
        @(posedge clk);
        store_register(REG_UNUSED, junk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_enabled && rst_n && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        drive_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_drive_q.size() == 0)
                report_mismatch("result with no request pending");
            else
            begin
                want = expected_drive_q.pop_front();
                if (drive_value !== want.drive)
                    report_mismatch($sformatf("drive_value got %0d expected %0d",
                                              drive_value, want.drive));
                if (saturated !== want.sat)
                    report_mismatch($sformatf("saturated got %0b expected %0b",
                                              saturated, want.sat));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int        n;
        int        seg_len;
        stim_row_t row;
        clk              = 1'b0;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        error_sample     = '0;
        restart          = 1'b0;
        cfg_write        = 1'b0;
        cfg_index        = REG_GAIN_P;
        cfg_data         = '0;
        gain_p           = '0;
        gain_i           = '0;
        gain_d           = '0;
        integral_state   = '0;
        prev_error_state = '0;
        mismatch_count   = 0;
        items_sent       = 0;
        quiet_cycles     = 0;
        idle_enabled     = 1'b1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < DIRECTED_ROWS; n++)
        begin
            row = DIRECTED[n];
            if (row.kind == ROW_GAINS)
            begin
                wait_idle();
                program_gains(row.p, row.i, row.d);
            end
            else
                send_request(row.err, row.restart, row.typed, '{row.drive, row.sat});
        end

        // push the integral into its upper clamp with every gain at maximum
        wait_idle();
        program_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (n = 0; n < WINDUP_LEN; n++)
            send_request(16'($urandom_range(30000, 32767)), n == 0, 1'b0, '0);

        // and into the lower clamp under random gains
        wait_idle();
        program_gains(pick_gain(), pick_gain(), pick_gain());
        for (n = 0; n < WINDUP_LEN; n++)
            send_request(16'($urandom_range(32768, 35536)), n == 0, 1'b0, '0);

        while (items_sent < ITEMS_TOTAL)
        begin
            wait_idle();
            program_gains(pick_gain(), pick_gain(), pick_gain());
            seg_len = $urandom_range(20, 60);
            for (n = 0; n < seg_len && items_sent < ITEMS_TOTAL; n++)
                send_request(random_error(), $urandom_range(0, 9) == 0, 1'b0, '0);
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
